// ===== rtl/slotted_page_tuple_store_macros.svh =====
// Assertion macros used by the checker file of the slotted page tuple store.
`ifndef SLOTTED_PAGE_TUPLE_STORE_MACROS_SVH
`define SLOTTED_PAGE_TUPLE_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/spts_pkg.sv =====
// Types, sizes and codes of the slotted page tuple store.
`timescale 1ns / 1ps

package spts_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_SLOTS    = 1024;
    localparam int SLOT_COST    = 4;

    localparam int ADDR_W   = $clog2(PAGE_BYTES);
    localparam int SPACE_W  = $clog2(PAGE_BYTES + 1);
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int COUNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LEN_W    = 13;
    localparam int AREA_W   = $clog2(HEADER_BYTES + SLOT_COST * MAX_SLOTS + 1);
    localparam int CALC_W   = ((AREA_W > LEN_W) ? AREA_W : LEN_W) + 1;
    localparam int RECV_MAX = (1 << LEN_W) - 1;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TAKEN    = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_NO_SLOT  = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;
    localparam logic [2:0] ST_BEYOND   = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  slot_index;
        logic [12:0] tuple_length;
        logic [11:0] byte_index;
        logic [7:0]  data_byte;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_id;
        logic [7:0]  read_byte;
        logic [12:0] stored_length;
        logic [12:0] free_space;
        logic [9:0]  slot_count;
        logic        deleted;
    } result_t;

    typedef struct packed {
        logic accept;
        logic byte_rd;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_byte;
    } dp_status_t;

endpackage

// ===== rtl/spts_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module spts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spts_dp.sv =====
// Datapath: page state, slot directory, tuple memory and result register.
`timescale 1ns / 1ps

module spts_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  spts_pkg::item_t     item,
    input  spts_pkg::ctrl_cmd_t cmd,
    output spts_pkg::dp_status_t stat,
    output spts_pkg::result_t   result
);

    spts_pkg::item_t                    item_reg;
    spts_pkg::result_t                  result_reg, result_next;
    logic [spts_pkg::SPACE_W-1:0]       free_offset_reg, free_offset_next;
    logic [spts_pkg::COUNT_W-1:0]       slots_used_reg, slots_used_next;
    logic                               add_active_reg, add_active_next;
    logic                               add_discarding_reg, add_discarding_next;
    logic [spts_pkg::LEN_W-1:0]         add_received_reg, add_received_next;
    logic [spts_pkg::LEN_W-1:0]         add_declared_reg, add_declared_next;

    logic [spts_pkg::ADDR_W-1:0]        off_rd;
    logic [spts_pkg::LEN_W-1:0]         len_rd;
    logic [7:0]                         byte_rd_data;

    logic [2:0]                         op;
    logic                               slot_ok, len_zero, byte_in_range;
    logic [spts_pkg::CALC_W-1:0]        space_cur, base_full;
    logic                               starting, room, fits, discard, commit, store_byte;
    logic [spts_pkg::LEN_W-1:0]         declared, received, recv_inc;
    logic [spts_pkg::ADDR_W-1:0]        base_addr, byte_waddr, rd_addr;
    logic                               byte_we, off_we, len_we;
    logic [spts_pkg::SLOT_W-1:0]        len_waddr;
    logic [spts_pkg::LEN_W-1:0]         len_wdata;

    function automatic logic [spts_pkg::CALC_W-1:0] space_left(
        input logic [spts_pkg::SPACE_W-1:0] free,
        input logic [spts_pkg::COUNT_W-1:0] used
    );
        logic [spts_pkg::CALC_W-1:0] area;
        logic [spts_pkg::CALC_W-1:0] f;
        area = spts_pkg::CALC_W'(spts_pkg::HEADER_BYTES)
             + spts_pkg::CALC_W'(used) * spts_pkg::CALC_W'(spts_pkg::SLOT_COST);
        f    = spts_pkg::CALC_W'(free);
        return (f >= area) ? (f - area) : '0;
    endfunction

    spts_ram #(.WIDTH(spts_pkg::ADDR_W), .DEPTH(spts_pkg::MAX_SLOTS)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (spts_pkg::SLOT_W'(slots_used_reg)),
        .wdata (base_addr),
        .re    (cmd.accept),
        .raddr (spts_pkg::SLOT_W'(item.slot_index)),
        .rdata (off_rd)
    );

    spts_ram #(.WIDTH(spts_pkg::LEN_W), .DEPTH(spts_pkg::MAX_SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (cmd.accept),
        .raddr (spts_pkg::SLOT_W'(item.slot_index)),
        .rdata (len_rd)
    );

    spts_ram #(.WIDTH(8), .DEPTH(spts_pkg::PAGE_BYTES)) u_tuple_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (item_reg.data_byte),
        .re    (cmd.byte_rd),
        .raddr (rd_addr),
        .rdata (byte_rd_data)
    );

    // Slot lookup checks
    always_comb
    begin
        op            = item_reg.opcode;
        slot_ok       = spts_pkg::COUNT_W'(item_reg.slot_index) < slots_used_reg;
        len_zero      = (len_rd == '0);
        byte_in_range = spts_pkg::LEN_W'(item_reg.byte_index) < len_rd;
        stat.need_byte = (op == spts_pkg::OP_READ) && slot_ok && !len_zero && byte_in_range;
        rd_addr       = off_rd + spts_pkg::ADDR_W'(item_reg.byte_index);
    end

    // Add byte bookkeeping; a new tuple samples its length on the first beat
    always_comb
    begin
        space_cur  = space_left(free_offset_reg, slots_used_reg);
        starting   = !add_active_reg;
        declared   = starting ? item_reg.tuple_length : add_declared_reg;
        room       = slots_used_reg < spts_pkg::COUNT_W'(spts_pkg::MAX_SLOTS);
        fits       = (item_reg.tuple_length != '0) && room
                   && (space_cur >= spts_pkg::CALC_W'(item_reg.tuple_length)
                                    + spts_pkg::CALC_W'(spts_pkg::SLOT_COST));
        discard    = starting ? !fits : add_discarding_reg;
        received   = starting ? '0 : add_received_reg;
        base_full  = spts_pkg::CALC_W'(free_offset_reg) - spts_pkg::CALC_W'(declared);
        base_addr  = base_full[spts_pkg::ADDR_W-1:0];
        recv_inc   = (received < spts_pkg::LEN_W'(spts_pkg::RECV_MAX))
                   ? received + spts_pkg::LEN_W'(1) : received;
        commit     = !discard && item_reg.last && (recv_inc == declared) && room;
        store_byte = !discard && (received < declared);
        byte_waddr = base_addr + spts_pkg::ADDR_W'(received);
    end

    // Memory writes happen only on the finishing cycle of an item
    always_comb
    begin
        byte_we   = cmd.finish && (op == spts_pkg::OP_ADD) && store_byte;
        off_we    = cmd.finish && (op == spts_pkg::OP_ADD) && commit;
        len_we    = off_we || (cmd.finish && (op == spts_pkg::OP_DELETE) && slot_ok);
        len_waddr = (op == spts_pkg::OP_DELETE) ? spts_pkg::SLOT_W'(item_reg.slot_index)
                                                : spts_pkg::SLOT_W'(slots_used_reg);
        len_wdata = (op == spts_pkg::OP_DELETE) ? '0 : declared;
    end

    always_comb
    begin
        free_offset_next    = free_offset_reg;
        slots_used_next     = slots_used_reg;
        add_active_next     = add_active_reg;
        add_discarding_next = add_discarding_reg;
        add_received_next   = add_received_reg;
        add_declared_next   = add_declared_reg;
        if (cmd.finish)
        begin
            if (op == spts_pkg::OP_CLEAR)
            begin
                free_offset_next    = spts_pkg::SPACE_W'(spts_pkg::PAGE_BYTES);
                slots_used_next     = '0;
                add_active_next     = 1'b0;
                add_discarding_next = 1'b0;
                add_received_next   = '0;
                add_declared_next   = '0;
            end
            else if (op == spts_pkg::OP_ADD)
            begin
                add_declared_next = declared;
                add_active_next   = !item_reg.last;
                if (discard)
                begin
                    add_received_next   = received;
                    add_discarding_next = !item_reg.last;
                end
                else
                begin
                    add_received_next   = recv_inc;
                    add_discarding_next = 1'b0;
                    if (commit)
                    begin
                        slots_used_next  = slots_used_reg + spts_pkg::COUNT_W'(1);
                        free_offset_next = spts_pkg::SPACE_W'(base_full);
                    end
                end
            end
        end
    end

    always_comb
    begin
        result_next               = '0;
        result_next.free_space    = 13'(space_left(free_offset_next, slots_used_next));
        result_next.slot_count    = 10'(slots_used_next);
        unique case (op)
            spts_pkg::OP_CLEAR:
            begin
                result_next.status = spts_pkg::ST_OK;
            end
            spts_pkg::OP_ADD:
            begin
                if (discard)
                begin
                    result_next.status = spts_pkg::ST_REJECT;
                end
                else if (!item_reg.last)
                begin
                    result_next.status = spts_pkg::ST_TAKEN;
                end
                else if (commit)
                begin
                    result_next.status        = spts_pkg::ST_OK;
                    result_next.slot_id       = 10'(slots_used_reg);
                    result_next.stored_length = declared;
                end
                else
                begin
                    result_next.status = spts_pkg::ST_MISMATCH;
                end
            end
            spts_pkg::OP_READ, spts_pkg::OP_DELETE, spts_pkg::OP_QUERY:
            begin
                result_next.slot_id = item_reg.slot_index;
                if (!slot_ok)
                begin
                    result_next.status  = spts_pkg::ST_NO_SLOT;
                    result_next.deleted = (op == spts_pkg::OP_QUERY);
                end
                else if (op == spts_pkg::OP_DELETE)
                begin
                    result_next.status = spts_pkg::ST_OK;
                end
                else
                begin
                    result_next.stored_length = len_rd;
                    if (len_zero)
                    begin
                        result_next.status  = spts_pkg::ST_DELETED;
                        result_next.deleted = (op == spts_pkg::OP_QUERY);
                    end
                    else if ((op == spts_pkg::OP_READ) && !byte_in_range)
                    begin
                        result_next.status = spts_pkg::ST_BEYOND;
                    end
                    else
                    begin
                        result_next.status = spts_pkg::ST_OK;
                        if (op == spts_pkg::OP_READ)
                        begin
                            result_next.read_byte = byte_rd_data;
                        end
                    end
                end
            end
            default:
            begin
                result_next.status = spts_pkg::ST_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_offset_reg    <= spts_pkg::SPACE_W'(spts_pkg::PAGE_BYTES);
            slots_used_reg     <= '0;
            add_active_reg     <= 1'b0;
            add_discarding_reg <= 1'b0;
            add_received_reg   <= '0;
            add_declared_reg   <= '0;
        end
        else
        begin
            free_offset_reg    <= free_offset_next;
            slots_used_reg     <= slots_used_next;
            add_active_reg     <= add_active_next;
            add_discarding_reg <= add_discarding_next;
            add_received_reg   <= add_received_next;
            add_declared_reg   <= add_declared_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/spts_ctrl.sv =====
// Controller: sequences slot lookup, tuple byte fetch and result hand-off.
`timescale 1ns / 1ps

module spts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 result_stall,
    input  spts_pkg::dp_status_t stat,
    output spts_pkg::ctrl_cmd_t  cmd,
    output logic                 item_stall,
    output logic                 result_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SLOT = 2'd1;
    localparam logic [1:0] S_BYTE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                // Slot data is ready; fetch the tuple byte or finish
                if (stat.need_byte)
                begin
                    cmd.byte_rd = 1'b1;
                    state_next  = S_BYTE;
                end
                else if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BYTE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until the receiver takes it
    assign out_valid_next = cmd.finish || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/slotted_page_tuple_store.sv =====
// Top level of the slotted page tuple store: controller plus datapath.
//
//   channel   direction  handshake                    beat
//   item      in         item_valid / item_stall      spts_pkg::item_t
//   result    out        result_valid / result_stall  spts_pkg::result_t
//
// One item at a time: an item is accepted, its slot entry is read from the
// slot directory RAMs in the next cycle, and the result is registered when
// the result register is free; a read byte that hits a live tuple first
// takes a second registered read from the tuple RAM. A waiting result beat
// does not block acceptance; a finished item holds in the controller while
// the result register is stalled. Reset is asynchronous and needs no sweep.
`timescale 1ns / 1ps

module slotted_page_tuple_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  spts_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output spts_pkg::result_t result
);

    spts_pkg::ctrl_cmd_t  cmd;
    spts_pkg::dp_status_t stat;

    spts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    spts_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// ===== rtl/spts_checker.sv =====
// Port-level checker for the slotted page tuple store, bound to the top level.
`timescale 1ns / 1ps
`include "slotted_page_tuple_store_macros.svh"

module spts_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input spts_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input spts_pkg::result_t result
);

    `SPTS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
    `SPTS_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall)
    `SPTS_ASSERT_NOW(a_deleted_status, result_valid && result.deleted, result.status == spts_pkg::ST_NO_SLOT || result.status == spts_pkg::ST_DELETED)
    `SPTS_ASSERT_NOW(a_byte_only_ok, result_valid && (result.read_byte != 8'd0), result.status == spts_pkg::ST_OK)

endmodule

bind slotted_page_tuple_store spts_checker u_spts_checker (.*);
